// File: rtl/rbu_pkg.sv
`default_nettype none

package rbu_pkg;

  localparam int CHANNEL_BITS   = 8;
  localparam int COORD_BITS     = 11;
  localparam int REG_BITS       = 11;
  localparam int APB_ADDR_BITS  = 3;
  localparam int APB_DATA_BITS  = 32;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_CENTRE = 2'd0,
    KIND_VERT   = 2'd1,
    KIND_HORIZ  = 2'd2,
    KIND_ORIG   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } in_pix_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] out_red;
    logic [CHANNEL_BITS-1:0] out_green;
    logic [CHANNEL_BITS-1:0] out_blue;
    logic [COORD_BITS-1:0]   out_row;
    logic [COORD_BITS-1:0]   out_col;
    logic                    last_of_run;
    logic                    frame_done;
  } out_pix_t;

  typedef struct packed {
    logic [REG_BITS-1:0] image_width;
    logic [REG_BITS-1:0] image_height;
  } cfg_t;

  typedef struct packed {
    in_pix_t               cur;
    in_pix_t               left;
    in_pix_t               above_left;
    logic [COORD_BITS-1:0] row2;
    logic [COORD_BITS-1:0] col2;
    logic                  has_up;
    logic                  has_left;
    logic                  frame_last;
  } item_t;

endpackage

`default_nettype wire

// File: rtl/rbu_stream_if.sv
`default_nettype none

interface rbu_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (
    output valid,
    output payload,
    input  ready
  );

  modport sink (
    input  valid,
    input  payload,
    output ready
  );

endinterface

`default_nettype wire

// File: rtl/rgb_bilinear_upscale_2x.sv
// Channel   Direction  Handshake          Carries
// pix_i     in         valid/ready        one input pixel (red, green, blue)
// res_o     out        valid/ready        one output pixel with row, column and flags
// APB       in         psel/penable       image_width at 0x0, image_height at 0x4
//
// A pixel causes one to four output pixels, all made by the single emitter that drives
// the output register one pixel per cycle while res_o is not stalled.
// The next pixel is taken in the cycle in which the last output of the previous one
// is produced, so after the first row a pixel causes four outputs, or two in column zero.
// After reset the counters are at the first pixel of a frame; the line buffer needs
// no clearing. A stall on res_o holds the output register and in turn pix_i.
`default_nettype none

module rgb_bilinear_upscale_2x
  import rbu_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  rbu_stream_if.sink               pix_i,
  rbu_stream_if.source             res_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = (CW + 1 > REG_BITS) ? CW + 1 : REG_BITS;
  localparam int HW = (RW + 1 > REG_BITS) ? RW + 1 : REG_BITS;

  cfg_t          cfg;
  logic [WW-1:0] w_reg;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_reg;
  logic [HW-1:0] h_eff;
  logic [CW-1:0] col_q;
  logic [CW-1:0] col_d;
  logic [RW-1:0] row_q;
  logic [RW-1:0] row_d;
  logic [WW-1:0] col_inc;
  logic [HW-1:0] row_inc;
  logic          last_col;
  logic          last_row;
  in_pix_t       left_q;
  in_pix_t       above;
  item_t         item;
  logic          accept;
  logic          take;
  logic          busy;
  logic          out_valid;
  out_pix_t      out_pix;

  rbu_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign w_reg = WW'(cfg.image_width);
  assign h_reg = HW'(cfg.image_height);
  assign w_eff = (w_reg == '0) ? WW'(1) :
                 (w_reg > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_reg;
  assign h_eff = (h_reg == '0) ? HW'(1) :
                 (h_reg > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : h_reg;

  assign col_inc  = WW'(col_q) + WW'(1);
  assign row_inc  = HW'(row_q) + HW'(1);
  assign last_col = (col_inc >= w_eff);
  assign last_row = (row_inc >= h_eff);

  assign accept      = pix_i.valid && take;
  assign pix_i.ready = take;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_inc[RW-1:0];
      end else begin
        col_d = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      left_q <= pix_i.payload;
    end
  end

  always_comb begin
    item.cur        = pix_i.payload;
    item.left       = left_q;
    item.above_left = above;
    item.row2       = COORD_BITS'({row_q, 1'b0});
    item.col2       = COORD_BITS'({col_q, 1'b0});
    item.has_up     = (row_q != '0);
    item.has_left   = (col_q != '0);
    item.frame_last = last_col && last_row;
  end

  rbu_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_buf (
    .clk_i   (clk_i),
    .en_i    (accept),
    .addr_i  (col_q),
    .wdata_i (pix_i.payload),
    .rdata_o (above)
  );

  rbu_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .item_i      (item),
    .above_i     (above),
    .out_ready_i (res_o.ready),
    .take_o      (take),
    .busy_o      (busy),
    .out_valid_o (out_valid),
    .out_o       (out_pix)
  );

  assign res_o.valid   = out_valid;
  assign res_o.payload = out_pix;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("emitter idle after a transaction was taken");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.payload.frame_done |-> res_o.payload.last_of_run)
    else $error("frame end flagged on an output that is not the last of its run");

  a_orig_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.payload.last_of_run |->
      !res_o.payload.out_row[0] && !res_o.payload.out_col[0])
    else $error("last output of a run is not an original pixel position");

endmodule

`default_nettype wire

// File: rtl/rbu_regs.sv
`default_nettype none

module rbu_regs
  import rbu_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg_o
);

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[2]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_WIDTH:  cfg_d.image_width  = pwdata[REG_BITS-1:0];
        REG_HEIGHT: cfg_d.image_height = pwdata[REG_BITS-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= REG_BITS'(1);
      cfg_q.image_height <= REG_BITS'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      REG_WIDTH:  prdata = APB_DATA_BITS'(cfg_q.image_width);
      REG_HEIGHT: prdata = APB_DATA_BITS'(cfg_q.image_height);
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/rbu_line_buf.sv
`default_nettype none

module rbu_line_buf
  import rbu_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_WIDTH,
  parameter int AW    = $clog2(DEF_MAX_WIDTH)
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [AW-1:0] addr_i,
  input  in_pix_t       wdata_i,
  output in_pix_t       rdata_o
);

  in_pix_t mem [DEPTH];
  in_pix_t rdata_q;

  assign rdata_o = rdata_q;

  // Read-first: the old entry is returned while the new pixel replaces it.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q      <= mem[addr_i];
      mem[addr_i]  <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rbu_emit.sv
`default_nettype none

module rbu_emit
  import rbu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  item_t    item_i,
  input  in_pix_t  above_i,
  input  logic     out_ready_i,
  output logic     take_o,
  output logic     busy_o,
  output logic     out_valid_o,
  output out_pix_t out_o
);

  item_t    item_q;
  logic [3:0] mask_q;
  logic [3:0] mask_d;
  logic     busy_q;
  logic     busy_d;
  logic     out_valid_q;
  logic     out_valid_d;
  out_pix_t out_q;
  out_pix_t out_d;
  logic     can_out;
  logic     fire;
  logic     last;
  kind_e    kind;
  logic [3:0] remaining;

  function automatic logic [CHANNEL_BITS-1:0] avg2(input logic [CHANNEL_BITS-1:0] a,
                                                   input logic [CHANNEL_BITS-1:0] b);
    logic [CHANNEL_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CHANNEL_BITS:1];
  endfunction

  function automatic logic [CHANNEL_BITS-1:0] avg4(input logic [CHANNEL_BITS-1:0] a,
                                                   input logic [CHANNEL_BITS-1:0] b,
                                                   input logic [CHANNEL_BITS-1:0] c,
                                                   input logic [CHANNEL_BITS-1:0] d);
    logic [CHANNEL_BITS+1:0] s;
    s = (CHANNEL_BITS+2)'(a) + (CHANNEL_BITS+2)'(b) + (CHANNEL_BITS+2)'(c)
      + (CHANNEL_BITS+2)'(d);
    return s[CHANNEL_BITS+1:2];
  endfunction

  always_comb begin
    kind = KIND_ORIG;
    if (mask_q[KIND_CENTRE]) begin
      kind = KIND_CENTRE;
    end else if (mask_q[KIND_VERT]) begin
      kind = KIND_VERT;
    end else if (mask_q[KIND_HORIZ]) begin
      kind = KIND_HORIZ;
    end
  end

  assign remaining = mask_q & ~(4'b0001 << kind);
  assign last      = (remaining == 4'b0000);
  assign can_out   = !out_valid_q || out_ready_i;
  assign fire      = busy_q && can_out;
  assign take_o    = !busy_q || (fire && last);
  assign busy_o    = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_o     = out_q;

  always_comb begin
    out_d             = out_q;
    out_d.out_row     = item_q.row2;
    out_d.out_col     = item_q.col2;
    out_d.last_of_run = last;
    out_d.frame_done  = last && item_q.frame_last;
    case (kind)
      KIND_CENTRE: begin
        out_d.out_red   = avg4(item_q.above_left.red, above_i.red,
                               item_q.left.red, item_q.cur.red);
        out_d.out_green = avg4(item_q.above_left.green, above_i.green,
                               item_q.left.green, item_q.cur.green);
        out_d.out_blue  = avg4(item_q.above_left.blue, above_i.blue,
                               item_q.left.blue, item_q.cur.blue);
        out_d.out_row   = item_q.row2 - COORD_BITS'(1);
        out_d.out_col   = item_q.col2 - COORD_BITS'(1);
      end
      KIND_VERT: begin
        out_d.out_red   = avg2(above_i.red, item_q.cur.red);
        out_d.out_green = avg2(above_i.green, item_q.cur.green);
        out_d.out_blue  = avg2(above_i.blue, item_q.cur.blue);
        out_d.out_row   = item_q.row2 - COORD_BITS'(1);
      end
      KIND_HORIZ: begin
        out_d.out_red   = avg2(item_q.left.red, item_q.cur.red);
        out_d.out_green = avg2(item_q.left.green, item_q.cur.green);
        out_d.out_blue  = avg2(item_q.left.blue, item_q.cur.blue);
        out_d.out_col   = item_q.col2 - COORD_BITS'(1);
      end
      default: begin
        out_d.out_red   = item_q.cur.red;
        out_d.out_green = item_q.cur.green;
        out_d.out_blue  = item_q.cur.blue;
      end
    endcase
  end

  always_comb begin
    mask_d = mask_q;
    busy_d = busy_q;
    if (load_i) begin
      mask_d = {1'b1, item_i.has_left, item_i.has_up, item_i.has_up && item_i.has_left};
      busy_d = 1'b1;
    end else if (fire) begin
      mask_d = remaining;
      busy_d = !last;
    end
  end

  always_comb begin
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire
